>>> hdl/apct_pkg.sv
// Shared types and constants for the rectangle pair collision table.
package apct_pkg;

  localparam logic [2:0] FN_ADD   = 3'd0;
  localparam logic [2:0] FN_SETR  = 3'd1;
  localparam logic [2:0] FN_SETE  = 3'd2;
  localparam logic [2:0] FN_MARK  = 3'd3;
  localparam logic [2:0] FN_SWEEP = 3'd4;

  localparam logic [63:0] PAIR_MASK_RST = 64'd1162017352087899136;

  typedef enum logic [2:0] {
    CK_ADD,
    CK_SETR,
    CK_SETE,
    CK_MARK,
    CK_SWEEP,
    CK_NOP
  } cmd_kind_t;

  typedef enum logic [1:0] {
    TAG_ADD  = 2'd0,
    TAG_PAIR = 2'd1,
    TAG_DONE = 2'd2,
    TAG_ACK  = 2'd3
  } tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH
  } back_st_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [2:0]         slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [2:0]         collider_kind;
    logic [7:0]         owner;
    logic               enable;
  } cmd_t;

  typedef struct packed {
    tag_t       tag;
    logic [2:0] first_slot;
    logic [2:0] second_slot;
    logic [7:0] first_owner;
    logic [7:0] second_owner;
    logic       notify_first;
    logic       notify_second;
    logic       full_res;
    logic       last;
  } res_t;

endpackage

>>> hdl/aabb_pair_collision_table.sv
// Add, set, mark and unknown commands give one result beat each, from the idle state.
// A sweep walks SLOTS*(SLOTS-1)/2 slot pairs, one pair read and overlap test per cycle from
// the two-port slot memory, then passes a drain and a finish state before its done beat; a
// full result queue stalls the walk.
// Reset is synchronous: the table empties and the filter mask returns to its default value.
// Slot contents are not cleared, as the contents of unoccupied slots are never used.
module aabb_pair_collision_table
  import apct_pkg::*;
#(
  parameter int SLOTS      = 8,
  parameter int COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         in_func,
  input  logic [2:0]         in_slot,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [14:0]        in_width,
  input  logic [14:0]        in_height,
  input  logic [2:0]         in_collider_kind,
  input  logic [7:0]         in_owner,
  input  logic               in_enable,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         out_tag,
  output logic [2:0]         out_first_slot,
  output logic [2:0]         out_second_slot,
  output logic [7:0]         out_first_owner,
  output logic [7:0]         out_second_owner,
  output logic               out_notify_first,
  output logic               out_notify_second,
  output logic               out_full_res,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [63:0]        cfg_data
);

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t res;
  logic res_push, res_space;

  apct_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_func          (in_func),
    .in_slot          (in_slot),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_width         (in_width),
    .in_height        (in_height),
    .in_collider_kind (in_collider_kind),
    .in_owner         (in_owner),
    .in_enable        (in_enable),
    .cmd_valid        (cmd_valid),
    .cmd_pop          (cmd_pop),
    .cmd              (cmd)
  );

  apct_back #(
    .SLOTS      (SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .res_push  (res_push),
    .res       (res),
    .res_space (res_space)
  );

  apct_resq u_resq (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_push          (res_push),
    .res               (res),
    .res_space         (res_space),
    .empty             (empty),
    .pop               (pop),
    .out_tag           (out_tag),
    .out_first_slot    (out_first_slot),
    .out_second_slot   (out_second_slot),
    .out_first_owner   (out_first_owner),
    .out_second_owner  (out_second_owner),
    .out_notify_first  (out_notify_first),
    .out_notify_second (out_notify_second),
    .out_full_res      (out_full_res),
    .out_last          (out_last)
  );

endmodule

>>> hdl/apct_front.sv
// Front end: accepts input beats, decodes the function code and queues commands.
module apct_front
  import apct_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         in_func,
  input  logic [2:0]         in_slot,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [14:0]        in_width,
  input  logic [14:0]        in_height,
  input  logic [2:0]         in_collider_kind,
  input  logic [7:0]         in_owner,
  input  logic               in_enable,
  output logic               cmd_valid,
  input  logic               cmd_pop,
  output cmd_t               cmd
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;
  logic       do_push, do_pop;

  always_comb begin
    case (in_func)
      FN_ADD:   dec.kind = CK_ADD;
      FN_SETR:  dec.kind = CK_SETR;
      FN_SETE:  dec.kind = CK_SETE;
      FN_MARK:  dec.kind = CK_MARK;
      FN_SWEEP: dec.kind = CK_SWEEP;
      default:  dec.kind = CK_NOP;
    endcase
    dec.slot          = in_slot;
    dec.pos_x         = in_pos_x;
    dec.pos_y         = in_pos_y;
    dec.width         = in_width;
    dec.height        = in_height;
    dec.collider_kind = in_collider_kind;
    dec.owner         = in_owner;
    dec.enable        = in_enable;
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

>>> hdl/apct_back.sv
// Back end: slot table, filter mask and the pairwise sweep engine.
module apct_back
  import apct_pkg::*;
#(
  parameter int SLOTS      = 8,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_pop,
  input  cmd_t        cmd,
  input  logic        cfg_we,
  input  logic [63:0] cfg_data,
  output logic        res_push,
  output res_t        res,
  input  logic        res_space
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int EW    = ((COORD_BITS > 15) ? COORD_BITS : 15) + 2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic [14:0]                  w;
    logic [14:0]                  h;
  } rect_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] owner;
  } meta_t;

  rect_t rect_mem [SLOTS];
  meta_t meta_mem [SLOTS];
  rect_t rect_a_r, rect_b_r, rect_wdata;
  meta_t meta_a_r, meta_b_r, meta_wdata;
  logic  rect_we, meta_we, rd_en;
  logic [IDX_W-1:0] wr_addr;

  back_st_t         state_r, state_nxt;
  logic [SLOTS-1:0] used_r, used_nxt;
  logic [SLOTS-1:0] enab_r, enab_nxt;
  logic [SLOTS-1:0] mark_r, mark_nxt;
  logic [63:0]      mask_r;
  logic [IDX_W-1:0] pi_r, pi_nxt, pk_r, pk_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  logic [IDX_W-1:0] s1_i_r, s1_i_nxt, s1_k_r, s1_k_nxt;

  logic             found;
  logic [IDX_W-1:0] free_idx;
  logic             slot_ok;
  logic [IDX_W-1:0] tgt;
  logic             pair_last;

  logic signed [EW-1:0] ax, ay, bx, by, aw, ah, bw, bh;
  logic                 hit, nf, ns, s1_emit, s1_done;

  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int j = 0; j < SLOTS; j++) begin
      if (!found && !used_r[j]) begin
        found    = 1'b1;
        free_idx = IDX_W'(j);
      end
    end
  end

  assign slot_ok   = (32'(cmd.slot) < SLOTS);
  assign tgt       = IDX_W'(cmd.slot);
  assign pair_last = (pi_r == IDX_W'(SLOTS - 2)) && (pk_r == IDX_W'(SLOTS - 1));

  always_comb begin
    rect_wdata.left = COORD_BITS'(32'(cmd.pos_x));
    rect_wdata.top  = COORD_BITS'(32'(cmd.pos_y));
    rect_wdata.w    = cmd.width;
    rect_wdata.h    = cmd.height;
    meta_wdata.kind  = cmd.collider_kind;
    meta_wdata.owner = cmd.owner;
  end

  always_comb begin
    ax = EW'(rect_a_r.left);
    ay = EW'(rect_a_r.top);
    bx = EW'(rect_b_r.left);
    by = EW'(rect_b_r.top);
    aw = $signed({{(EW-15){1'b0}}, rect_a_r.w});
    ah = $signed({{(EW-15){1'b0}}, rect_a_r.h});
    bw = $signed({{(EW-15){1'b0}}, rect_b_r.w});
    bh = $signed({{(EW-15){1'b0}}, rect_b_r.h});
    hit = !((ax + aw < bx) || (bx + bw < ax) || (ay + ah < by) || (by + bh < ay));
    nf = mask_r[{meta_a_r.kind, meta_b_r.kind}] && (meta_a_r.owner != 8'd0);
    ns = mask_r[{meta_b_r.kind, meta_a_r.kind}] && (meta_b_r.owner != 8'd0);
    s1_emit = s1_valid_r && hit && (nf || ns);
    s1_done = !s1_emit || res_space;
  end

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    enab_nxt     = enab_r;
    mark_nxt     = mark_r;
    pi_nxt       = pi_r;
    pk_nxt       = pk_r;
    s1_valid_nxt = s1_valid_r;
    s1_i_nxt     = s1_i_r;
    s1_k_nxt     = s1_k_r;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    res          = '0;
    rect_we      = 1'b0;
    meta_we      = 1'b0;
    rd_en        = 1'b0;
    wr_addr      = tgt;

    if (s1_emit && res_space) begin
      res_push          = 1'b1;
      res.tag           = TAG_PAIR;
      res.first_slot    = 3'(s1_i_r);
      res.second_slot   = 3'(s1_k_r);
      res.first_owner   = meta_a_r.owner;
      res.second_owner  = meta_b_r.owner;
      res.notify_first  = nf;
      res.notify_second = ns;
    end

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && res_space) begin
          cmd_pop = 1'b1;
          if (cmd.kind != CK_SWEEP) begin
            res_push = 1'b1;
            res.tag  = TAG_ACK;
            res.last = 1'b1;
          end
          case (cmd.kind)
            CK_ADD: begin
              res.tag = TAG_ADD;
              if (found) begin
                wr_addr            = free_idx;
                rect_we            = 1'b1;
                meta_we            = 1'b1;
                used_nxt[free_idx] = 1'b1;
                enab_nxt[free_idx] = 1'b1;
                mark_nxt[free_idx] = 1'b0;
                res.first_slot     = 3'(free_idx);
              end else begin
                res.full_res = 1'b1;
              end
            end
            CK_SETR: begin
              rect_we = slot_ok && used_r[tgt];
            end
            CK_SETE: begin
              if (slot_ok && used_r[tgt]) begin
                enab_nxt[tgt] = cmd.enable;
              end
            end
            CK_MARK: begin
              if (slot_ok && used_r[tgt]) begin
                mark_nxt[tgt] = 1'b1;
              end
            end
            CK_SWEEP: begin
              used_nxt  = used_r & ~mark_r;
              mark_nxt  = mark_r & ~used_r;
              pi_nxt    = '0;
              pk_nxt    = IDX_W'(1);
              state_nxt = ST_SWEEP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SWEEP: begin
        if (s1_done) begin
          rd_en        = 1'b1;
          s1_valid_nxt = used_r[pi_r] && enab_r[pi_r] && used_r[pk_r];
          s1_i_nxt     = pi_r;
          s1_k_nxt     = pk_r;
          if (pair_last) begin
            state_nxt = ST_DRAIN;
          end else if (pk_r == IDX_W'(SLOTS - 1)) begin
            pi_nxt = pi_r + 1'b1;
            pk_nxt = IDX_W'(pi_r + 2'd2);
          end else begin
            pk_nxt = pk_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (s1_done) begin
          s1_valid_nxt = 1'b0;
          state_nxt    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (res_space) begin
          res_push  = 1'b1;
          res.tag   = TAG_DONE;
          res.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      used_r     <= '0;
      enab_r     <= '0;
      mark_r     <= '0;
      pi_r       <= '0;
      pk_r       <= '0;
      s1_valid_r <= 1'b0;
      mask_r     <= PAIR_MASK_RST;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      enab_r     <= enab_nxt;
      mark_r     <= mark_nxt;
      pi_r       <= pi_nxt;
      pk_r       <= pk_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (cfg_we) begin
        mask_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_i_r <= s1_i_nxt;
    s1_k_r <= s1_k_nxt;
  end

  always_ff @(posedge clk) begin
    if (rect_we) begin
      rect_mem[wr_addr] <= rect_wdata;
    end
    if (rd_en) begin
      rect_a_r <= rect_mem[pi_r];
      rect_b_r <= rect_mem[pk_r];
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[wr_addr] <= meta_wdata;
    end
    if (rd_en) begin
      meta_a_r <= meta_mem[pi_r];
      meta_b_r <= meta_mem[pk_r];
    end
  end

endmodule

>>> hdl/apct_resq.sv
// Two-entry result queue that drives the result ports.
module apct_resq
  import apct_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       res_push,
  input  res_t       res,
  output logic       res_space,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_tag,
  output logic [2:0] out_first_slot,
  output logic [2:0] out_second_slot,
  output logic [7:0] out_first_owner,
  output logic [7:0] out_second_owner,
  output logic       out_notify_first,
  output logic       out_notify_second,
  output logic       out_full_res,
  output logic       out_last
);

  res_t       q_r [2];
  res_t       head;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign res_space = (cnt_r != 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign do_push   = res_push && res_space;
  assign do_pop    = pop && !empty;
  assign head      = q_r[rd_ptr_r];

  assign out_tag           = head.tag;
  assign out_first_slot    = head.first_slot;
  assign out_second_slot   = head.second_slot;
  assign out_first_owner   = head.first_owner;
  assign out_second_owner  = head.second_owner;
  assign out_notify_first  = head.notify_first;
  assign out_notify_second = head.notify_second;
  assign out_full_res      = head.full_res;
  assign out_last          = head.last;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= res;
    end
  end

endmodule

>>> tb/aabb_pair_collision_table_tb.sv
// Self-checking testbench for the rectangle pair collision table with a predictor and random traffic.
module aabb_pair_collision_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import apct_pkg::*;

  localparam int SLOTS = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [2:0] FN_TOP = 3'd7;

  typedef struct {
    logic [2:0]         func;
    logic [2:0]         slot;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
    logic [2:0]         kind;
    logic [7:0]         owner;
    logic               en;
  } beat_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               push;
  logic               full;
  logic [2:0]         in_func;
  logic [2:0]         in_slot;
  logic signed [15:0] in_pos_x;
  logic signed [15:0] in_pos_y;
  logic [14:0]        in_width;
  logic [14:0]        in_height;
  logic [2:0]         in_collider_kind;
  logic [7:0]         in_owner;
  logic               in_enable;
  logic               empty;
  logic               pop;
  logic [1:0]         out_tag;
  logic [2:0]         out_first_slot;
  logic [2:0]         out_second_slot;
  logic [7:0]         out_first_owner;
  logic [7:0]         out_second_owner;
  logic               out_notify_first;
  logic               out_notify_second;
  logic               out_full_res;
  logic               out_last;
  logic               cfg_we;
  logic [63:0]        cfg_data;

  logic [63:0]        mask_model;
  bit                 used_m [SLOTS];
  bit                 mark_m [SLOTS];
  bit                 en_m [SLOTS];
  logic [2:0]         kind_m [SLOTS];
  logic [7:0]         owner_m [SLOTS];
  logic signed [15:0] left_m [SLOTS];
  logic signed [15:0] top_m [SLOTS];
  logic [14:0]        wid_m [SLOTS];
  logic [14:0]        hgt_m [SLOTS];
  res_t               reply_q [$];

  int errors;
  int cmds_sent;
  int pair_events;
  int sweeps_seen;
  int full_replies;
  int stall_cycles;
  int hold_left;
  bit steady;

  aabb_pair_collision_table u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_func           (in_func),
    .in_slot           (in_slot),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_width          (in_width),
    .in_height         (in_height),
    .in_collider_kind  (in_collider_kind),
    .in_owner          (in_owner),
    .in_enable         (in_enable),
    .empty             (empty),
    .pop               (pop),
    .out_tag           (out_tag),
    .out_first_slot    (out_first_slot),
    .out_second_slot   (out_second_slot),
    .out_first_owner   (out_first_owner),
    .out_second_owner  (out_second_owner),
    .out_notify_first  (out_notify_first),
    .out_notify_second (out_notify_second),
    .out_full_res      (out_full_res),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit rects_touch(int a, int b);
    int ax, ay, aw, ah, bx, by, bw, bh;
    ax = left_m[a];
    ay = top_m[a];
    aw = wid_m[a];
    ah = hgt_m[a];
    bx = left_m[b];
    by = top_m[b];
    bw = wid_m[b];
    bh = hgt_m[b];
    return !(ax + aw < bx || bx + bw < ax || ay + ah < by || by + bh < ay);
  endfunction

  function automatic void store_rect(int s, beat_t b);
    left_m[s] = b.x;
    top_m[s]  = b.y;
    wid_m[s]  = b.w;
    hgt_m[s]  = b.h;
  endfunction

  function automatic void apply_table_cmd(beat_t b);
    res_t r;
    int   i, k;
    bit   placed, nf, ns;
    r = '0;
    r.last = 1'b1;
    case (b.func)
      FN_ADD: begin
        placed = 1'b0;
        for (i = 0; i < SLOTS && !placed; i++) begin
          if (!used_m[i]) begin
            used_m[i]  = 1'b1;
            mark_m[i]  = 1'b0;
            en_m[i]    = 1'b1;
            kind_m[i]  = b.kind;
            owner_m[i] = b.owner;
            store_rect(i, b);
            r.first_slot = 3'(i);
            placed = 1'b1;
          end
        end
        r.tag = TAG_ADD;
        r.full_res = !placed;
        reply_q.push_back(r);
      end
      FN_SWEEP: begin
        for (i = 0; i < SLOTS; i++) begin
          if (used_m[i] && mark_m[i]) begin
            used_m[i] = 1'b0;
            mark_m[i] = 1'b0;
          end
        end
        for (i = 0; i < SLOTS; i++) begin
          if (used_m[i] && en_m[i]) begin
            for (k = i + 1; k < SLOTS; k++) begin
              if (used_m[k] && rects_touch(i, k)) begin
                nf = mask_model[{kind_m[i], kind_m[k]}] && owner_m[i] != 8'd0;
                ns = mask_model[{kind_m[k], kind_m[i]}] && owner_m[k] != 8'd0;
                if (nf || ns) begin
                  r = '0;
                  r.tag = TAG_PAIR;
                  r.first_slot = 3'(i);
                  r.second_slot = 3'(k);
                  r.first_owner = owner_m[i];
                  r.second_owner = owner_m[k];
                  r.notify_first = nf;
                  r.notify_second = ns;
                  reply_q.push_back(r);
                end
              end
            end
          end
        end
        r = '0;
        r.tag = TAG_DONE;
        r.last = 1'b1;
        reply_q.push_back(r);
      end
      default: begin
        if (used_m[b.slot]) begin
          case (b.func)
            FN_SETR: store_rect(b.slot, b);
            FN_SETE: en_m[b.slot] = b.en;
            FN_MARK: mark_m[b.slot] = 1'b1;
            default: ;
          endcase
        end
        r.tag = TAG_ACK;
        reply_q.push_back(r);
      end
    endcase
  endfunction

  function automatic beat_t cmd_beat(logic [2:0] func, logic [2:0] slot,
                                     logic signed [15:0] x, logic signed [15:0] y,
                                     logic [14:0] w, logic [14:0] h, logic [2:0] kind,
                                     logic [7:0] owner, logic en);
    beat_t b;
    b.func = func;
    b.slot = slot;
    b.x = x;
    b.y = y;
    b.w = w;
    b.h = h;
    b.kind = kind;
    b.owner = owner;
    b.en = en;
    return b;
  endfunction

  function automatic beat_t rand_beat(logic [2:0] func);
    beat_t b;
    b.func = func;
    b.slot = 3'($urandom_range(SLOTS - 1));
    b.kind = 3'($urandom_range(7));
    b.owner = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255));
    b.en = 1'($urandom_range(1));
    if ($urandom_range(9) == 0) begin
      b.x = 16'($urandom);
      b.y = 16'($urandom);
      b.w = 15'($urandom);
      b.h = 15'($urandom);
    end else begin
      b.x = 16'(int'($urandom_range(160)) - 80);
      b.y = 16'(int'($urandom_range(160)) - 80);
      b.w = 15'($urandom_range(48));
      b.h = 15'($urandom_range(48));
    end
    return b;
  endfunction

  function automatic logic [2:0] pick_func();
    int n, r;
    n = 0;
    foreach (used_m[i]) n += used_m[i];
    r = $urandom_range(99);
    if (n < 3 && r < 50) return FN_ADD;
    if (r < 25) return FN_ADD;
    if (r < 40) return FN_SETR;
    if (r < 55) return FN_SETE;
    if (r < 67) return FN_MARK;
    if (r < 92) return FN_SWEEP;
    return 3'($urandom_range(FN_TOP, FN_SWEEP + 3'd1));
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic check_result();
    res_t want;
    if (reply_q.size() == 0) begin
      report_mismatch($sformatf("result beat with tag %0d arrived unexpected", out_tag));
      return;
    end
    want = reply_q.pop_front();
    check_field("tag", out_tag, want.tag);
    check_field("first_slot", out_first_slot, want.first_slot);
    check_field("second_slot", out_second_slot, want.second_slot);
    check_field("first_owner", out_first_owner, want.first_owner);
    check_field("second_owner", out_second_owner, want.second_owner);
    check_field("notify_first", out_notify_first, want.notify_first);
    check_field("notify_second", out_notify_second, want.notify_second);
    check_field("full_res", out_full_res, want.full_res);
    check_field("last", out_last, want.last);
    if (want.tag == TAG_PAIR) pair_events++;
    if (want.tag == TAG_DONE) sweeps_seen++;
    if (want.full_res) full_replies++;
  endtask

  task automatic send_beat(beat_t b);
    while (!steady && $urandom_range(99) < 29) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_func <= b.func;
    in_slot <= b.slot;
    in_pos_x <= b.x;
    in_pos_y <= b.y;
    in_width <= b.w;
    in_height <= b.h;
    in_collider_kind <= b.kind;
    in_owner <= b.owner;
    in_enable <= b.en;
    @(posedge clk);
    while (full) begin
      stall_cycles++;
      @(posedge clk);
    end
    apply_table_cmd(b);
    cmds_sent++;
    @(negedge clk);
  endtask

  task automatic drain_replies();
    push <= 1'b0;
    while (reply_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_pair_mask(logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    mask_model = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed_table();
    int f;
    load_pair_mask('1);
    send_beat(cmd_beat(FN_ADD, 3'd0, 0, 0, 10, 10, 3'd1, 8'hFF, 1'b0));
    send_beat(cmd_beat(FN_ADD, 3'd0, 10, 10, 5, 5, 3'd2, 8'h01, 1'b0));
    send_beat(cmd_beat(FN_ADD, 3'd0, 16, 0, 3, 3, 3'd3, 8'h80, 1'b0));
    send_beat(cmd_beat(FN_ADD, 3'd0, 32767, 32767, 32767, 32767, 3'd7, 8'h7F, 1'b0));
    send_beat(cmd_beat(FN_ADD, 3'd0, -32768, -32768, 0, 0, 3'd0, 8'h00, 1'b0));
    send_beat(cmd_beat(FN_ADD, 3'd0, -32768, -32768, 32767, 32767, 3'd4, 8'h02, 1'b0));
    send_beat(cmd_beat(FN_ADD, 3'd0, -1, -1, 1, 1, 3'd5, 8'h03, 1'b0));
    send_beat(cmd_beat(FN_ADD, 3'd0, -2, -2, 0, 0, 3'd6, 8'h04, 1'b0));
    send_beat(cmd_beat(FN_ADD, 3'd7, 5, 5, 5, 5, 3'd7, 8'hAA, 1'b1));
    send_beat(cmd_beat(FN_SWEEP, 3'd0, 0, 0, 0, 0, 3'd0, 8'h00, 1'b0));
    send_beat(cmd_beat(FN_SETE, 3'd0, 0, 0, 0, 0, 3'd0, 8'h00, 1'b0));
    send_beat(cmd_beat(FN_SETR, 3'd1, -20, -20, 20, 20, 3'd0, 8'h00, 1'b0));
    send_beat(cmd_beat(FN_MARK, 3'd2, 0, 0, 0, 0, 3'd0, 8'h00, 1'b0));
    for (f = FN_SWEEP + 1; f <= FN_TOP; f++) begin
      send_beat(cmd_beat(3'(f), 3'd7, 1, 1, 1, 1, 3'd7, 8'hFF, 1'b1));
    end
    send_beat(cmd_beat(FN_SWEEP, 3'd0, 0, 0, 0, 0, 3'd0, 8'h00, 1'b0));
    send_beat(cmd_beat(FN_MARK, 3'd2, 0, 0, 0, 0, 3'd0, 8'h00, 1'b0));
    send_beat(cmd_beat(FN_SETR, 3'd2, 0, 0, 100, 100, 3'd0, 8'h00, 1'b0));
    send_beat(cmd_beat(FN_SETE, 3'd2, 0, 0, 0, 0, 3'd0, 8'h00, 1'b1));
    send_beat(cmd_beat(FN_ADD, 3'd0, 12, 0, 4, 4, 3'd3, 8'h80, 1'b1));
    send_beat(cmd_beat(FN_SWEEP, 3'd0, 0, 0, 0, 0, 3'd0, 8'h00, 1'b0));
  endtask

  task automatic test_output_backpressure();
    beat_t b;
    int i;
    drain_replies();
    load_pair_mask('1);
    for (i = 0; i < SLOTS; i++) begin
      send_beat(cmd_beat(FN_MARK, 3'(i), 0, 0, 0, 0, 3'd0, 8'h00, 1'b0));
    end
    send_beat(cmd_beat(FN_SWEEP, 3'd0, 0, 0, 0, 0, 3'd0, 8'h00, 1'b0));
    for (i = 0; i < SLOTS; i++) begin
      b = rand_beat(FN_ADD);
      b.x = 16'($urandom_range(20));
      b.y = 16'($urandom_range(20));
      b.w = 15'd40;
      b.h = 15'd40;
      b.owner = 8'($urandom_range(255, 1));
      send_beat(b);
    end
    hold_left = 400;
    repeat (10) send_beat(cmd_beat(FN_SWEEP, 3'd0, 0, 0, 0, 0, 3'd0, 8'h00, 1'b0));
    drain_replies();
  endtask

  task automatic test_random_traffic();
    logic [63:0] masks [5];
    int phase;
    masks[0] = '0;
    masks[1] = '1;
    masks[2] = PAIR_MASK_RST;
    masks[3] = {$urandom, $urandom};
    masks[4] = {$urandom, $urandom};
    for (phase = 0; phase < 5; phase++) begin
      drain_replies();
      load_pair_mask(masks[phase]);
      steady = (phase == 2);
      repeat (45) send_beat(rand_beat(pick_func()));
    end
    steady = 1'b0;
  endtask

  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) check_result();
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(99) >= 29);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d result beats outstanding", reply_q.size());
    $display("aabb_pair_collision_table_tb failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_func = FN_ADD;
    in_slot = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_width = '0;
    in_height = '0;
    in_collider_kind = '0;
    in_owner = '0;
    in_enable = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    mask_model = PAIR_MASK_RST;
    foreach (used_m[i]) begin
      used_m[i] = 1'b0;
      mark_m[i] = 1'b0;
      en_m[i] = 1'b0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);
    test_directed_table();
    test_output_backpressure();
    test_random_traffic();
    drain_replies();
    $display("covered %0d commands and %0d sweeps with %0d pair events, %0d full-table adds",
             cmds_sent, sweeps_seen, pair_events, full_replies);
    $display("input held back %0d cycles; filter masks zero, all ones, default and random",
             stall_cycles);
    if (errors == 0) begin
      $display("aabb_pair_collision_table_tb passed");
    end else begin
      $display("aabb_pair_collision_table_tb failed");
    end
    $finish;
  end

endmodule
